>>> hw/rtl/uraf_pkg.sv
// Shared types, codes and constants of the UART register access framer.
// Used by the channel interfaces and every module of the block; no dependencies.
package uraf_pkg;

	// Most words one input word can produce (a write request frame).
	localparam int NUM_SLOTS = 5;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

	// Input word kinds.
	localparam logic [1:0] MODE_READ    = 2'd0;
	localparam logic [1:0] MODE_WRITE   = 2'd1;
	localparam logic [1:0] MODE_RX      = 2'd2;
	localparam logic [1:0] MODE_TIMEOUT = 2'd3;

	// Transaction status codes.
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_NO_RESPONSE  = 3'd1;
	localparam logic [2:0] ST_DEVICE_ERROR = 3'd2;
	localparam logic [2:0] ST_BAD_HEADER   = 3'd3;
	localparam logic [2:0] ST_TOO_LONG     = 3'd4;
	localparam logic [2:0] ST_TOO_SHORT    = 3'd5;
	localparam logic [2:0] ST_WRITE_FAILED = 3'd6;

	// Protocol bytes.
	localparam logic [7:0] SYNC_BYTE   = 8'hAA;
	localparam logic [7:0] CMD_WRITE   = 8'h00;
	localparam logic [7:0] CMD_READ    = 8'h01;
	localparam logic [7:0] WRITE_COUNT = 8'h01;
	localparam logic [7:0] RESP_OK     = 8'hBB;
	localparam logic [7:0] RESP_ERR    = 8'hEE;
	localparam logic [7:0] WRITE_ACK   = 8'h01;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] reg_addr;
		logic [7:0] read_length;
		logic [7:0] write_value;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       tx_last;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       data_last;
		logic       done_res;
		logic [2:0] status;
		logic [7:0] device_code;
	} result_t;

	// Group of result words produced by one input word, slot 0 goes out first.
	typedef struct packed {
		logic [CNT_W-1:0]            count;
		result_t [NUM_SLOTS-1:0]     res;
	} batch_t;

endpackage

>>> hw/rtl/uraf_cmd_if.sv
// Valid/ready channel that carries input words into the framer.
// Depends on uraf_pkg for the word type.
interface uraf_cmd_if import uraf_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/uraf_rsp_if.sv
// Valid/ready channel that carries result words out of the framer.
// Depends on uraf_pkg for the word type.
interface uraf_rsp_if import uraf_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/uraf_engine.sv
// Transaction state and per-word decode: frame building and reply parsing.
// Depends on uraf_pkg.
module uraf_engine import uraf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  item_t  item,
	output batch_t batch
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HDR    = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;
	localparam logic [1:0] PH_DATA   = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic       is_write_q, is_write_d;
	logic [7:0] req_len_q, req_len_d;
	logic [7:0] remaining_q, remaining_d;
	logic [7:0] header_q, header_d;
	logic [7:0] remaining_dec;

	function automatic result_t tx_word(input logic [7:0] b, input logic last);
		result_t r;
		r          = '0;
		r.tx_valid = 1'b1;
		r.tx_byte  = b;
		r.tx_last  = last;
		return r;
	endfunction

	function automatic result_t done_word(input logic [2:0] st, input logic [7:0] code);
		result_t r;
		r             = '0;
		r.done_res    = 1'b1;
		r.status      = st;
		r.device_code = code;
		return r;
	endfunction

	assign remaining_dec = remaining_q - 8'd1;

	always_comb begin
		phase_d     = phase_q;
		is_write_d  = is_write_q;
		req_len_d   = req_len_q;
		remaining_d = remaining_q;
		header_d    = header_q;
		batch       = '0;
		case (item.mode)
			MODE_READ: begin
				batch.res[0] = tx_word(SYNC_BYTE, 1'b0);
				batch.res[1] = tx_word(CMD_READ, 1'b0);
				batch.res[2] = tx_word(item.reg_addr, 1'b0);
				batch.res[3] = tx_word(item.read_length, 1'b1);
				batch.count  = CNT_W'(4);
				is_write_d   = 1'b0;
				req_len_d    = item.read_length;
				remaining_d  = '0;
				header_d     = '0;
				phase_d      = PH_HDR;
			end
			MODE_WRITE: begin
				batch.res[0] = tx_word(SYNC_BYTE, 1'b0);
				batch.res[1] = tx_word(CMD_WRITE, 1'b0);
				batch.res[2] = tx_word(item.reg_addr, 1'b0);
				batch.res[3] = tx_word(WRITE_COUNT, 1'b0);
				batch.res[4] = tx_word(item.write_value, 1'b1);
				batch.count  = CNT_W'(5);
				is_write_d   = 1'b1;
				remaining_d  = '0;
				header_d     = '0;
				phase_d      = PH_HDR;
			end
			MODE_TIMEOUT: begin
				if (phase_q != PH_IDLE) begin
					batch.res[0] = done_word((phase_q == PH_DATA) ? ST_TOO_SHORT
						: ST_NO_RESPONSE, 8'h00);
					batch.count  = CNT_W'(1);
					phase_d      = PH_IDLE;
					remaining_d  = '0;
				end
			end
			default: begin
				// A received byte; ignored while idle.
				case (phase_q)
					PH_HDR: begin
						header_d = item.rx_byte;
						phase_d  = PH_SECOND;
					end
					PH_SECOND: begin
						phase_d     = PH_IDLE;
						batch.count = CNT_W'(1);
						if (is_write_q) begin
							if (header_q == RESP_ERR) begin
								batch.res[0] = done_word((item.rx_byte == WRITE_ACK)
									? ST_OK : ST_WRITE_FAILED, item.rx_byte);
							end else begin
								batch.res[0] = done_word(ST_WRITE_FAILED, 8'h00);
							end
						end else if (header_q == RESP_ERR) begin
							batch.res[0] = done_word(ST_DEVICE_ERROR, item.rx_byte);
						end else if (header_q == RESP_OK) begin
							if (item.rx_byte > req_len_q) begin
								batch.res[0] = done_word(ST_TOO_LONG, 8'h00);
							end else if (item.rx_byte == 8'h00) begin
								batch.res[0] = done_word(ST_OK, 8'h00);
							end else begin
								remaining_d = item.rx_byte;
								phase_d     = PH_DATA;
								batch.count = '0;
							end
						end else begin
							batch.res[0] = done_word(ST_BAD_HEADER, 8'h00);
						end
					end
					PH_DATA: begin
						batch.count                = CNT_W'(1);
						batch.res[0].data_valid    = 1'b1;
						batch.res[0].data_byte     = item.rx_byte;
						remaining_d                = remaining_dec;
						if (remaining_dec == 8'h00) begin
							batch.res[0].data_last = 1'b1;
							batch.res[0].done_res  = 1'b1;
							batch.res[0].status    = ST_OK;
							phase_d                = PH_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			is_write_q  <= 1'b0;
			req_len_q   <= '0;
			remaining_q <= '0;
			header_q    <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			is_write_q  <= is_write_d;
			req_len_q   <= req_len_d;
			remaining_q <= remaining_d;
			header_q    <= header_d;
		end
	end

endmodule

>>> hw/rtl/uraf_emitter.sv
// Result buffer: holds the words of one input word and sends them one per handshake.
// Depends on uraf_pkg and uraf_rsp_if.
module uraf_emitter import uraf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  batch_t      batch,
	output logic        can_load,
	uraf_rsp_if.source  rsp
);

	result_t [NUM_SLOTS-1:0] res_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    pop;

	assign rsp.valid = (cnt_q != '0);
	assign rsp.data  = res_q[0];
	assign pop       = rsp.valid && rsp.ready;
	// A new batch may land when the buffer is empty or its last word leaves now.
	assign can_load  = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= batch.count;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= batch.res;
		end else if (pop) begin
			for (int i = 0; i < NUM_SLOTS - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

endmodule

>>> hw/rtl/uart_register_access_framer_core.sv
// UART register access framer, host side. An input word is decoded in the cycle it is
// accepted and its result words (up to five) are visible from the cycle after.
// Throughput: one input word per cycle, limited by the output channel, which moves one
// result word per cycle while the receiver is ready; a request frame thus occupies the
// output for its four or five words. Reset (arst_n low, asynchronous) returns the
// transaction to idle and empties the result buffer.
module uart_register_access_framer_core import uraf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	uraf_cmd_if.sink   cmd,
	uraf_rsp_if.source rsp
);

	// The engine holds the transaction state (phase, request kind, requested length,
	// bytes still due and the header byte seen) and works out, from the incoming word
	// and that state, the whole group of result words it causes. The group is written
	// into the emitter's buffer in the same edge that updates the state, so the next
	// input word always sees the state left by the previous one.
	logic   accept;
	logic   can_load;
	batch_t batch;

	// Input is taken whenever the buffer can take a new group; words that cause no
	// result (a header byte, a stray byte or tick while idle) pass straight through.
	assign cmd.ready = can_load;
	assign accept    = cmd.valid && cmd.ready;

	uraf_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (cmd.data),
		.batch  (batch)
	);

	uraf_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.batch    (batch),
		.can_load (can_load),
		.rsp      (rsp)
	);

	// An empty buffer must always be able to take a word.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid |-> cmd.ready)
		else $error("input stalled while no result is pending");

	// Every request frame starts with the sync byte in the next cycle.
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.data.mode == MODE_READ || cmd.data.mode == MODE_WRITE))
		|=> (rsp.valid && rsp.data.tx_valid && rsp.data.tx_byte == SYNC_BYTE
		&& !rsp.data.tx_last))
		else $error("request frame does not start with the sync byte");

	// A result word carries either a frame byte or reply information, never both.
	a_tx_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.tx_valid) |-> (!rsp.data.done_res && !rsp.data.data_valid))
		else $error("frame byte mixed with reply information");

	// A data byte marked last always closes the transaction with status ok.
	a_data_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.data_last) |-> (rsp.data.done_res && rsp.data.status == ST_OK))
		else $error("last data byte without ok completion");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for uart_register_access_framer_core: a directed table, then
// random read/write exchanges and noise, checked against an in-bench protocol predictor.
// Depends on uraf_pkg and the uraf_cmd_if / uraf_rsp_if channel interfaces.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import uraf_pkg::*;

	// Number of input words that do real work before the random part stops.
	localparam int ITEM_TARGET = 410;

	// How a directed table row gets its expectation: from the predictor, or typed in.
	localparam int USE_MODEL = -1;
	localparam int NO_WORD   = 0;
	localparam int ONE_WORD  = 1;

	// Where the host is in one transaction: idle, waiting for the reply header byte,
	// waiting for the count/code byte, or collecting data bytes of a read.
	typedef enum logic [1:0] {
		WAIT_IDLE,
		WAIT_HEADER,
		WAIT_COUNT,
		WAIT_DATA
	} link_phase_t;

	// One row of the directed table. typed_n says whether the expectation is read off
	// the row itself (zero or one word) or left to the predictor.
	typedef struct {
		item_t   w;
		int      typed_n;
		result_t typed_word;
	} stim_row_t;

	logic clk;
	logic arst_n;

	uraf_cmd_if cmd_ch ();
	uraf_rsp_if rsp_ch ();

	uart_register_access_framer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Predictor state: a private copy of the transaction, reset values as after arst_n.
	link_phase_t link_phase    = WAIT_IDLE;
	bit          pend_is_write = 1'b0;
	logic [7:0]  pend_length   = '0;
	logic [7:0]  data_left     = '0;
	logic [7:0]  header_seen   = '0;

	// Result words still owed by the block, oldest first.
	result_t pending_words[$];

	int mismatch_count = 0;
	int useful_items   = 0;
	int read_reqs      = 0;
	int write_reqs     = 0;
	int words_checked  = 0;
	int data_words     = 0;
	int done_count [8];
	int burst_left     = 4;

	// Receiver stall pattern: which pattern is active and for how many more cycles.
	int rx_pattern = 0;
	int rx_left    = 0;

	result_t    want;
	string      diffs;
	stim_row_t  directed_rows[$];

	// The free-running clock, 8 ns period.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit: far beyond the slowest correct run (every word waiting out the longest
	// receiver stall and every input word the longest sender gap).
	initial begin
		#5_000_000;
		$display("Timeout: the run did not finish in time.");
		$display("CHECKS FAILED");
		$finish;
	end

	// Every mismatch passes through here: one line each, counted. After a few dozen lines
	// the printing stops so a broken block cannot flood the log, but counting goes on.
	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("[%0t ns] MISMATCH: %s", $realtime, what);
		end
	endtask

	// Builders for result words.
	function automatic result_t tx_word(input logic [7:0] b, input bit last);
		result_t r;
		r = '0;
		r.tx_valid = 1'b1;
		r.tx_byte = b;
		r.tx_last = last;
		return r;
	endfunction

	function automatic result_t done_word(input logic [2:0] st, input logic [7:0] code);
		result_t r;
		r = '0;
		r.done_res = 1'b1;
		r.status = st;
		r.device_code = code;
		return r;
	endfunction

	// Builders for input words. The fields that a given kind of word does not use are
	// filled with random bytes, so the block is seen to ignore them.
	function automatic item_t rd(input logic [7:0] addr, input logic [7:0] len);
		item_t w;
		w.mode = MODE_READ;
		w.reg_addr = addr;
		w.read_length = len;
		w.write_value = 8'($urandom_range(0, 255));
		w.rx_byte = 8'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic item_t wr(input logic [7:0] addr, input logic [7:0] val);
		item_t w;
		w.mode = MODE_WRITE;
		w.reg_addr = addr;
		w.read_length = 8'($urandom_range(0, 255));
		w.write_value = val;
		w.rx_byte = 8'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic item_t rx(input logic [7:0] b);
		item_t w;
		w.mode = MODE_RX;
		w.reg_addr = 8'($urandom_range(0, 255));
		w.read_length = 8'($urandom_range(0, 255));
		w.write_value = 8'($urandom_range(0, 255));
		w.rx_byte = b;
		return w;
	endfunction

	function automatic item_t tick();
		item_t w;
		w.mode = MODE_TIMEOUT;
		w.reg_addr = 8'($urandom_range(0, 255));
		w.read_length = 8'($urandom_range(0, 255));
		w.write_value = 8'($urandom_range(0, 255));
		w.rx_byte = 8'($urandom_range(0, 255));
		return w;
	endfunction

	// The predictor. A request emits its frame and arms the reply parser; a received
	// byte advances the parser; a timeout tick closes a wait that is still open. A new
	// request always wins, dropping whatever transaction was in flight without a done
	// word. Returns the number of result words, which are placed in batch.
	function automatic int frame_and_parse(input item_t w, output result_t batch [NUM_SLOTS]);
		int n;
		n = 0;
		foreach (batch[i]) batch[i] = '0;
		case (w.mode)
			MODE_READ: begin
				batch[0] = tx_word(SYNC_BYTE, 1'b0);
				batch[1] = tx_word(CMD_READ, 1'b0);
				batch[2] = tx_word(w.reg_addr, 1'b0);
				batch[3] = tx_word(w.read_length, 1'b1);
				n = 4;
				pend_is_write = 1'b0;
				pend_length = w.read_length;
				data_left = '0;
				header_seen = '0;
				link_phase = WAIT_HEADER;
			end
			MODE_WRITE: begin
				// The requested length of an earlier read is left as it was.
				batch[0] = tx_word(SYNC_BYTE, 1'b0);
				batch[1] = tx_word(CMD_WRITE, 1'b0);
				batch[2] = tx_word(w.reg_addr, 1'b0);
				batch[3] = tx_word(WRITE_COUNT, 1'b0);
				batch[4] = tx_word(w.write_value, 1'b1);
				n = 5;
				pend_is_write = 1'b1;
				data_left = '0;
				header_seen = '0;
				link_phase = WAIT_HEADER;
			end
			MODE_TIMEOUT: begin
				// A tick while idle is simply dropped.
				if (link_phase == WAIT_HEADER || link_phase == WAIT_COUNT) begin
					batch[0] = done_word(ST_NO_RESPONSE, 8'h00);
					n = 1;
				end else if (link_phase == WAIT_DATA) begin
					batch[0] = done_word(ST_TOO_SHORT, 8'h00);
					n = 1;
				end
				if (n != 0) begin
					link_phase = WAIT_IDLE;
					data_left = '0;
				end
			end
			default: begin
				case (link_phase)
					WAIT_HEADER: begin
						header_seen = w.rx_byte;
						link_phase = WAIT_COUNT;
					end
					WAIT_COUNT: begin
						link_phase = WAIT_IDLE;
						n = 1;
						if (pend_is_write) begin
							// Only an error header carrying the ack code means success.
							if (header_seen == RESP_ERR) begin
								batch[0] = done_word((w.rx_byte == WRITE_ACK)
									? ST_OK : ST_WRITE_FAILED, w.rx_byte);
							end else begin
								batch[0] = done_word(ST_WRITE_FAILED, 8'h00);
							end
						end else if (header_seen == RESP_ERR) begin
							batch[0] = done_word(ST_DEVICE_ERROR, w.rx_byte);
						end else if (header_seen == RESP_OK) begin
							if (w.rx_byte > pend_length) begin
								batch[0] = done_word(ST_TOO_LONG, 8'h00);
							end else if (w.rx_byte == 8'h00) begin
								batch[0] = done_word(ST_OK, 8'h00);
							end else begin
								// A good count opens the data phase; nothing is emitted yet.
								data_left = w.rx_byte;
								link_phase = WAIT_DATA;
								n = 0;
							end
						end else begin
							batch[0] = done_word(ST_BAD_HEADER, 8'h00);
						end
					end
					WAIT_DATA: begin
						batch[0].data_valid = 1'b1;
						batch[0].data_byte = w.rx_byte;
						data_left = data_left - 8'd1;
						if (data_left == 8'h00) begin
							// The last data byte also carries the done status.
							batch[0].data_last = 1'b1;
							batch[0].done_res = 1'b1;
							batch[0].status = ST_OK;
							link_phase = WAIT_IDLE;
						end
						n = 1;
					end
					default: begin
						// A byte with no transaction open is ignored.
					end
				endcase
			end
		endcase
		return n;
	endfunction

	// Offer one input word, wait for its handshake, and record what it should cause.
	// Prediction runs at the accepting edge; the block's words for it cannot appear
	// before the next edge, so the queue is always ahead of the output. The sender
	// works in bursts: when a burst runs out, valid drops for a random gap.
	task automatic issue(input item_t w, input int typed_n = USE_MODEL,
			input result_t typed_word = '0);
		result_t batch [NUM_SLOTS];
		int      n;
		int      i;
		int      gap;
		bit      was_idle;
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= w;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		was_idle = (link_phase == WAIT_IDLE);
		n = frame_and_parse(w, batch);
		if (typed_n == USE_MODEL) begin
			for (i = 0; i < n; i++) pending_words.push_back(batch[i]);
		end else if (typed_n == ONE_WORD) begin
			pending_words.push_back(typed_word);
		end
		// Received bytes and ticks that land on an idle block do no work.
		if (!(was_idle && (w.mode == MODE_RX || w.mode == MODE_TIMEOUT))) useful_items++;
		if (w.mode == MODE_READ) read_reqs++;
		if (w.mode == MODE_WRITE) write_reqs++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 5);
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			// Now and then a long burst, so that stretches run with no idling at all.
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 8);
		end
	endtask

	// A read request followed by one of the replies a device may give: mostly a good
	// count and its data (sometimes cut short by a tick), else error, oversized count,
	// bad header, silence, or a header byte left hanging for the next request to drop.
	task automatic read_exchange();
		logic [7:0] len;
		logic [7:0] hb;
		int         count;
		int         cut;
		int         kind;
		int         k;
		kind = $urandom_range(0, 39);
		if (kind == 0) len = 8'($urandom_range(100, 255));
		else if (kind == 1) len = 8'h00;
		else len = 8'($urandom_range(1, 8));
		issue(rd(8'($urandom_range(0, 255)), len));
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			// Large lengths mostly get short answers so the run stays brisk.
			if (len == 0) count = 0;
			else if (len > 8 && $urandom_range(0, 2) != 0) count = $urandom_range(1, 8);
			else count = $urandom_range(1, len);
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, count) : count;
			issue(rx(RESP_OK));
			issue(rx(8'(count)));
			for (k = 0; k < cut; k++) issue(rx(8'($urandom_range(0, 255))));
			if (cut < count) issue(tick());
		end else if (kind < 70) begin
			issue(rx(RESP_ERR));
			issue(rx(8'($urandom_range(0, 255))));
		end else if (kind < 80 && len != 8'hFF) begin
			issue(rx(RESP_OK));
			issue(rx(8'($urandom_range(int'(len) + 1, 255))));
		end else if (kind < 90) begin
			do hb = 8'($urandom_range(0, 255)); while (hb == RESP_OK || hb == RESP_ERR);
			issue(rx(hb));
			issue(rx(8'($urandom_range(0, 255))));
		end else if (kind < 94) begin
			issue(tick());
		end else if (kind < 98) begin
			issue(rx(8'($urandom_range(0, 255))));
			issue(tick());
		end else begin
			issue(rx(8'($urandom_range(0, 255))));
		end
	endtask

	// A write request and its reply: the ack, an error code, some other header, a
	// timeout, or no reply at all so that the next request drops it.
	task automatic write_exchange();
		int kind;
		issue(wr(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			issue(rx(RESP_ERR));
			issue(rx(WRITE_ACK));
		end else if (kind < 70) begin
			issue(rx(RESP_ERR));
			issue(rx(8'($urandom_range(0, 255))));
		end else if (kind < 85) begin
			issue(rx(8'($urandom_range(0, 255))));
			issue(rx(8'($urandom_range(0, 255))));
		end else if (kind < 95) begin
			issue(tick());
		end
	endtask

	// Output checker: each accepted result word is compared field by field with the
	// oldest expectation. Also keeps the tallies for the summary.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			words_checked++;
			if (rsp_ch.data.data_valid === 1'b1) data_words++;
			if (rsp_ch.data.done_res === 1'b1) done_count[rsp_ch.data.status]++;
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("result word %h arrived with nothing expected",
					rsp_ch.data));
			end else begin
				want = pending_words.pop_front();
				diffs = "";
				if (rsp_ch.data.tx_valid !== want.tx_valid) diffs = {diffs, " tx_valid"};
				if (rsp_ch.data.tx_byte !== want.tx_byte) diffs = {diffs, " tx_byte"};
				if (rsp_ch.data.tx_last !== want.tx_last) diffs = {diffs, " tx_last"};
				if (rsp_ch.data.data_valid !== want.data_valid) diffs = {diffs, " data_valid"};
				if (rsp_ch.data.data_byte !== want.data_byte) diffs = {diffs, " data_byte"};
				if (rsp_ch.data.data_last !== want.data_last) diffs = {diffs, " data_last"};
				if (rsp_ch.data.done_res !== want.done_res) diffs = {diffs, " done_res"};
				if (rsp_ch.data.status !== want.status) diffs = {diffs, " status"};
				if (rsp_ch.data.device_code !== want.device_code) begin
					diffs = {diffs, " device_code"};
				end
				if (diffs != "") begin
					report_mismatch($sformatf("word %0d got %h want %h, differs in:%s",
						words_checked, rsp_ch.data, want, diffs));
				end
			end
		end
	end

	// Receiver back-pressure. A pattern runs for a random stretch: always ready, mostly
	// ready, mostly stalled, or a solid stall, then a new one is drawn.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_pattern = $urandom_range(0, 3);
			rx_left = $urandom_range(1, (rx_pattern == 3) ? 24 : 40);
		end
		rx_left--;
		case (rx_pattern)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			default: rsp_ch.ready <= 1'b0;
		endcase
	end

	// Main sequence: reset, the directed table, the random part, then the drain and
	// the verdict.
	initial begin
		int  r;
		int  k;
		bit  paused_once;
		paused_once = 1'b0;
		foreach (done_count[i]) done_count[i] = 0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. Rows whose outcome is plain from the protocol carry it typed in;
		// request frames and data words are left to the predictor.
		directed_rows = '{
			// Straight after reset: a tick and a stray byte on an idle block do nothing.
			'{tick(),               NO_WORD,   '0},
			'{rx(8'h55),            NO_WORD,   '0},
			// A one-byte read, answered by silence.
			'{rd(8'h00, 8'd1),      USE_MODEL, '0},
			'{tick(),               ONE_WORD,  done_word(ST_NO_RESPONSE, 8'h00)},
			// Write acknowledged.
			'{wr(8'hFF, 8'h00),     USE_MODEL, '0},
			'{rx(RESP_ERR),         NO_WORD,   '0},
			'{rx(WRITE_ACK),        ONE_WORD,  done_word(ST_OK, WRITE_ACK)},
			// Write refused with code zero.
			'{wr(8'h12, 8'hFF),     USE_MODEL, '0},
			'{rx(RESP_ERR),         NO_WORD,   '0},
			'{rx(8'h00),            ONE_WORD,  done_word(ST_WRITE_FAILED, 8'h00)},
			// Largest sensible length, count at the top of its range: too long.
			'{rd(8'h80, 8'd128),    USE_MODEL, '0},
			'{rx(RESP_OK),          NO_WORD,   '0},
			'{rx(8'hFF),            ONE_WORD,  done_word(ST_TOO_LONG, 8'h00)},
			// Zero-length read with a zero count is fine.
			'{rd(8'h5A, 8'd0),      USE_MODEL, '0},
			'{rx(RESP_OK),          NO_WORD,   '0},
			'{rx(8'h00),            ONE_WORD,  done_word(ST_OK, 8'h00)},
			// A write arrives mid-reply and drops the read; then a wrong header fails it.
			'{rd(8'hA5, 8'd2),      USE_MODEL, '0},
			'{rx(RESP_ERR),         NO_WORD,   '0},
			'{wr(8'h33, 8'hCC),     USE_MODEL, '0},
			'{rx(8'h13),            NO_WORD,   '0},
			'{rx(8'h02),            ONE_WORD,  done_word(ST_WRITE_FAILED, 8'h00)},
			// Data phase cut short by a tick.
			'{rd(8'h01, 8'd3),      USE_MODEL, '0},
			'{rx(RESP_OK),          NO_WORD,   '0},
			'{rx(8'h02),            NO_WORD,   '0},
			'{rx(8'hFF),            USE_MODEL, '0},
			'{tick(),               ONE_WORD,  done_word(ST_TOO_SHORT, 8'h00)},
			// Device error carries its code through.
			'{rd(8'h7E, 8'd1),      USE_MODEL, '0},
			'{rx(RESP_ERR),         NO_WORD,   '0},
			'{rx(8'hFF),            ONE_WORD,  done_word(ST_DEVICE_ERROR, 8'hFF)}
		};
		foreach (directed_rows[i]) begin
			issue(directed_rows[i].w, directed_rows[i].typed_n, directed_rows[i].typed_word);
		end

		// Random part: well-formed exchanges with random content, plus some noise words.
		while (useful_items < ITEM_TARGET) begin
			// Once, halfway, hold the sender off until every expected word is out.
			if (!paused_once && useful_items >= ITEM_TARGET / 2) begin
				paused_once = 1'b1;
				@(negedge clk);
				cmd_ch.valid <= 1'b0;
				while (pending_words.size() != 0) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 45) begin
				read_exchange();
			end else if (r < 80) begin
				write_exchange();
			end else begin
				repeat ($urandom_range(1, 3)) begin
					issue('{mode: 2'($urandom_range(0, 3)),
						reg_addr: 8'($urandom_range(0, 255)),
						read_length: 8'($urandom_range(0, 255)),
						write_value: 8'($urandom_range(0, 255)),
						rx_byte: 8'($urandom_range(0, 255))});
				end
			end
		end

		// Drain: stop offering words, wait for the queue to empty, then keep the clock running
		// so a stray extra word would still be caught.
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		for (k = 0; k < 5000 && pending_words.size() != 0; k++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_words.size() != 0) begin
			report_mismatch($sformatf("%0d expected result words never arrived",
				pending_words.size()));
		end

		$display({"Summary: %0d working input words (%0d reads, %0d writes), ",
			"%0d result words checked, %0d data bytes."},
			useful_items, read_reqs, write_reqs, words_checked, data_words);
		$display({"Transactions closed: ok %0d, no_response %0d, device_error %0d, ",
			"bad_header %0d, too_long %0d, too_short %0d, write_failed %0d."},
			done_count[ST_OK], done_count[ST_NO_RESPONSE], done_count[ST_DEVICE_ERROR],
			done_count[ST_BAD_HEADER], done_count[ST_TOO_LONG], done_count[ST_TOO_SHORT],
			done_count[ST_WRITE_FAILED]);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
